// ===== rtl/cmg_pkg.sv =====
// shared types, constants and helpers of the cylinder mesh generator
package cmg_pkg;

    localparam int MAX_SECTORS   = 1024;
    localparam int N_W           = 11;
    localparam int J_W           = 10;
    localparam int IDX_W         = 13;
    localparam int PHASE_W       = 32;
    localparam int DIV_BITS      = 4;
    localparam int DIV_STAGES    = PHASE_W / DIV_BITS;
    localparam int CORDIC_STEPS  = 30;
    localparam int TRIG_W        = 34;
    localparam int PROD_W        = 66;
    localparam int SUM_W         = 36;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int MAX_RESULTS   = 5;
    localparam int SLOT_W        = $clog2(MAX_RESULTS);
    localparam int ADDR_W        = 5;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sh26DD3B6A;
    localparam logic signed [PROD_W-1:0] ROUND_HALF  = 66'sd536870912;

    localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
    };

    localparam logic [1:0] KIND_VERTEX   = 2'd0;
    localparam logic [1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;

    localparam logic [1:0] RING_TOP    = 2'd0;
    localparam logic [1:0] RING_BOTTOM = 2'd1;
    localparam logic [1:0] RING_CAP    = 2'd2;
    localparam logic [1:0] RING_UNUSED = 2'd3;

    localparam logic [2:0] REG_RADIUS   = 3'd0;
    localparam logic [2:0] REG_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_CENTRE_X = 3'd2;
    localparam logic [2:0] REG_CENTRE_Y = 3'd3;
    localparam logic [2:0] REG_CENTRE_Z = 3'd4;
    localparam logic [2:0] REG_SECTORS  = 3'd5;

    typedef struct packed {
        logic [1:0]     ring;
        logic [J_W-1:0] sector;
    } t_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] first_word;
        logic signed [31:0] second_word;
        logic signed [31:0] third_word;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [1:0]     ring;
        logic [J_W-1:0] sector;
        logic           err;
        logic           drop;
    } t_tag;

    typedef struct packed {
        logic [1:0]         ring;
        logic [J_W-1:0]     sector;
        logic               err;
        logic signed [31:0] vx;
        logic signed [31:0] vz;
    } t_job;

    typedef struct packed {
        logic [30:0]        radius;
        logic [30:0]        height;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [N_W-1:0]     nsec;
    } t_cfg;

    typedef struct packed {
        logic             full;
        logic             empty;
        logic [Q_PTR_W:0] count;
    } t_q_status;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > SUM_W'(32'sh7FFFFFFF)) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -SUM_W'(33'sh080000000)) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/cmg_front.sv =====
// front: classify steps, divide out the phase, cordic and scale to vertex x/z
module cmg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  cmg_pkg::t_in  i_data,
    output logic          o_stall,
    input  cmg_pkg::t_cfg i_cfg,
    input  logic          i_q_full,
    output logic          o_push,
    output cmg_pkg::t_job o_job
);
    import cmg_pkg::*;

    logic en;

    // divider stages, index 0 is the entry register
    logic                 r_dv   [DIV_STAGES+1];
    t_tag                 r_dtag [DIV_STAGES+1];
    logic [N_W-1:0]       r_rem  [DIV_STAGES+1];
    logic [PHASE_W-1:0]   r_quo  [DIV_STAGES+1];

    // cordic stages
    logic                     r_cv   [CORDIC_STEPS+1];
    t_tag                     r_ctag [CORDIC_STEPS+1];
    logic [1:0]               r_cq   [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] r_cx   [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] r_cy   [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0] r_cz   [CORDIC_STEPS+1];

    logic                     r_mv;
    t_tag                     r_mtag;
    logic signed [PROD_W-1:0] r_pc;
    logic signed [PROD_W-1:0] r_ps;

    logic               r_pv;
    t_tag               r_ptag;
    logic signed [31:0] r_px;
    logic signed [31:0] r_pz;

    assign en      = !(r_pv && i_q_full);
    assign o_stall = !en;
    assign o_push  = r_pv && !r_ptag.drop && en;

    always_comb begin
        o_job.ring   = r_ptag.ring;
        o_job.sector = r_ptag.sector;
        o_job.err    = r_ptag.err;
        o_job.vx     = r_px;
        o_job.vz     = r_pz;
    end

    // entry: classify
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= i_valid;
        end
        if (en) begin
            r_dtag[0].ring   <= i_data.ring;
            r_dtag[0].sector <= i_data.sector;
            r_dtag[0].err    <= (i_data.ring == RING_UNUSED) ||
                                ({1'b0, i_data.sector} >= i_cfg.nsec);
            r_dtag[0].drop   <= (i_data.ring == RING_CAP) && (i_data.sector == '0) &&
                                ({1'b0, i_data.sector} < i_cfg.nsec);
            r_rem[0]         <= {1'b0, i_data.sector};
            r_quo[0]         <= '0;
        end
    end

    // restoring division of j * 2^32 by n, four (DIV_BITS) quotient bits per stage
    for (genvar gk = 1; gk <= DIV_STAGES; gk++) begin : g_div
        logic [N_W-1:0]      rem_nx;
        logic [DIV_BITS-1:0] bits_nx;

        always_comb begin
            logic [N_W:0] t;
            rem_nx  = r_rem[gk-1];
            bits_nx = '0;
            for (int b = DIV_BITS - 1; b >= 0; b--) begin
                t = {rem_nx, 1'b0};
                if (t >= {1'b0, i_cfg.nsec}) begin
                    rem_nx  = N_W'(t - {1'b0, i_cfg.nsec});
                    bits_nx[b] = 1'b1;
                end else begin
                    rem_nx  = t[N_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[gk] <= 1'b0;
            end else if (en) begin
                r_dv[gk] <= r_dv[gk-1];
            end
            if (en) begin
                r_dtag[gk] <= r_dtag[gk-1];
                r_rem[gk]  <= rem_nx;
                r_quo[gk]  <= {r_quo[gk-1][PHASE_W-DIV_BITS-1:0], bits_nx};
            end
        end
    end

    // cordic start: top phase bits pick the quadrant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_dv[DIV_STAGES];
        end
        if (en) begin
            r_ctag[0] <= r_dtag[DIV_STAGES];
            r_cq[0]   <= r_quo[DIV_STAGES][PHASE_W-1:PHASE_W-2];
            r_cx[0]   <= CORDIC_GAIN;
            r_cy[0]   <= '0;
            r_cz[0]   <= TRIG_W'({1'b0, r_quo[DIV_STAGES][PHASE_W-3:0]});
        end
    end

    for (genvar gi = 0; gi < CORDIC_STEPS; gi++) begin : g_cordic
        logic signed [TRIG_W-1:0] dx;
        logic signed [TRIG_W-1:0] dy;
        logic signed [TRIG_W-1:0] at;

        assign dx = r_cy[gi] >>> gi;
        assign dy = r_cx[gi] >>> gi;
        assign at = TRIG_W'(ATAN_TURN[gi]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[gi+1] <= 1'b0;
            end else if (en) begin
                r_cv[gi+1] <= r_cv[gi];
            end
            if (en) begin
                r_ctag[gi+1] <= r_ctag[gi];
                r_cq[gi+1]   <= r_cq[gi];
                if (!r_cz[gi][TRIG_W-1]) begin
                    r_cx[gi+1] <= r_cx[gi] - dx;
                    r_cy[gi+1] <= r_cy[gi] + dy;
                    r_cz[gi+1] <= r_cz[gi] - at;
                end else begin
                    r_cx[gi+1] <= r_cx[gi] + dx;
                    r_cy[gi+1] <= r_cy[gi] - dy;
                    r_cz[gi+1] <= r_cz[gi] + at;
                end
            end
        end
    end

    // quadrant fold and radius products
    logic signed [TRIG_W-1:0] cos_v;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [31:0]       rad_s;

    assign rad_s = $signed({1'b0, i_cfg.radius});

    always_comb begin
        case (r_cq[CORDIC_STEPS])
            2'd0: begin
                cos_v = r_cx[CORDIC_STEPS];
                sin_v = r_cy[CORDIC_STEPS];
            end
            2'd1: begin
                cos_v = -r_cy[CORDIC_STEPS];
                sin_v = r_cx[CORDIC_STEPS];
            end
            2'd2: begin
                cos_v = -r_cx[CORDIC_STEPS];
                sin_v = -r_cy[CORDIC_STEPS];
            end
            default: begin
                cos_v = r_cy[CORDIC_STEPS];
                sin_v = -r_cx[CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= r_cv[CORDIC_STEPS];
        end
        if (en) begin
            r_mtag <= r_ctag[CORDIC_STEPS];
            r_pc   <= rad_s * cos_v;
            r_ps   <= rad_s * sin_v;
        end
    end

    // round half up, add centre, saturate
    logic signed [PROD_W-1:0] rnd_c;
    logic signed [PROD_W-1:0] rnd_s;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_z;

    assign rnd_c = (r_pc + ROUND_HALF) >>> 30;
    assign rnd_s = (r_ps + ROUND_HALF) >>> 30;
    assign sum_x = SUM_W'(i_cfg.cx) + rnd_c[SUM_W-1:0];
    assign sum_z = SUM_W'(i_cfg.cz) + rnd_s[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= r_mv;
        end
        if (en) begin
            r_ptag <= r_mtag;
            r_px   <= sat32(sum_x);
            r_pz   <= sat32(sum_z);
        end
    end

endmodule

// ===== rtl/cmg_queue.sv =====
// short job queue between the front pipeline and the result sequencer
module cmg_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cmg_pkg::t_job      i_job,
    input  logic               i_pop,
    output cmg_pkg::t_job      o_job,
    output cmg_pkg::t_q_status o_status
);
    import cmg_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_PTR_W:0]   r_cnt;

    assign o_job           = r_mem[r_rp];
    assign o_status.count  = r_cnt;
    assign o_status.full   = (r_cnt == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_status.empty  = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== rtl/cmg_back.sv =====
// back: expands one queued job into its vertex, triangle or error beats
module cmg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cmg_pkg::t_cfg      i_cfg,
    input  cmg_pkg::t_job      i_job,
    input  cmg_pkg::t_q_status i_status,
    output logic               o_pop,
    output logic               o_valid,
    output cmg_pkg::t_out      o_data,
    input  logic               i_stall
);
    import cmg_pkg::*;

    function automatic t_out mk(input logic [1:0] kind, input logic signed [31:0] a,
                                input logic signed [31:0] b, input logic signed [31:0] c);
        t_out r;
        r.kind        = kind;
        r.first_word  = a;
        r.second_word = b;
        r.third_word  = c;
        r.last        = 1'b0;
        return r;
    endfunction

    function automatic logic signed [31:0] ix(input logic [IDX_W-1:0] v);
        return 32'(v);
    endfunction

    logic [SLOT_W-1:0] r_slot;
    logic              r_ovalid;
    t_out              r_out;
    t_out              n_out;

    t_out              list [MAX_RESULTS];
    logic [SLOT_W-1:0] cnt;
    logic signed [31:0] ytop;
    logic signed [31:0] ybot;
    logic              load;
    logic              is_last;

    assign ytop = sat32(SUM_W'(i_cfg.cy) + SUM_W'(i_cfg.height[30:1]));
    assign ybot = sat32(SUM_W'(i_cfg.cy) - SUM_W'(i_cfg.height[30:1]));

    always_comb begin
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] n;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] hub;
        logic             closing;
        j       = IDX_W'(i_job.sector);
        n       = IDX_W'(i_cfg.nsec);
        cur     = n + j + 1'b1;
        hub     = {n[IDX_W-2:0], 1'b0} + 1'b1;
        closing = (j == n - 1'b1);
        cnt     = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            list[k] = mk(KIND_ERROR, '0, '0, '0);
        end
        if (i_job.err) begin
            cnt = SLOT_W'(1);
        end else begin
            if (i_job.ring == RING_TOP && j == '0) begin
                list[cnt] = mk(KIND_VERTEX, i_cfg.cx, ytop, i_cfg.cz);
                cnt = cnt + 1'b1;
            end
            if (i_job.ring != RING_CAP) begin
                list[cnt] = mk(KIND_VERTEX, i_job.vx,
                               (i_job.ring == RING_TOP) ? ytop : ybot, i_job.vz);
                cnt = cnt + 1'b1;
            end
            if (j != '0) begin
                case (i_job.ring)
                    RING_TOP: begin
                        list[cnt] = mk(KIND_TRIANGLE, '0, ix(j + 1'b1), ix(j));
                        cnt = cnt + 1'b1;
                        if (closing) begin
                            list[cnt] = mk(KIND_TRIANGLE, '0, ix(n), ix(IDX_W'(1)));
                            cnt = cnt + 1'b1;
                        end
                    end
                    RING_BOTTOM: begin
                        list[cnt] = mk(KIND_TRIANGLE, ix(cur), ix(cur - 1'b1), ix(j));
                        cnt = cnt + 1'b1;
                        list[cnt] = mk(KIND_TRIANGLE, ix(cur), ix(j + 1'b1), ix(j));
                        cnt = cnt + 1'b1;
                        if (closing) begin
                            list[cnt] = mk(KIND_TRIANGLE, ix(cur), ix(j + 1'b1),
                                           ix(IDX_W'(1)));
                            cnt = cnt + 1'b1;
                            list[cnt] = mk(KIND_TRIANGLE, ix(cur), ix(j + 2'd2),
                                           ix(IDX_W'(1)));
                            cnt = cnt + 1'b1;
                        end
                    end
                    default: begin
                        // bottom cap fan, centre vertex comes with sector one
                        if (j == IDX_W'(1)) begin
                            list[cnt] = mk(KIND_VERTEX, i_cfg.cx, ybot, i_cfg.cz);
                            cnt = cnt + 1'b1;
                        end
                        list[cnt] = mk(KIND_TRIANGLE, ix(hub), ix(cur), ix(cur - 1'b1));
                        cnt = cnt + 1'b1;
                        if (closing) begin
                            list[cnt] = mk(KIND_TRIANGLE, ix(hub), ix(cur),
                                           ix(n + 1'b1));
                            cnt = cnt + 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    assign load    = !i_status.empty && (!r_ovalid || !i_stall);
    assign is_last = (r_slot == cnt - 1'b1);
    assign o_pop   = load && is_last;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_comb begin
        n_out      = list[r_slot];
        n_out.last = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_slot   <= '0;
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
                r_slot   <= is_last ? '0 : r_slot + 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/cylinder_mesh_generator.sv =====
// top level: register port, front pipeline, job queue and result sequencer
// a step passes the entry, divider, cordic, product and sum registers into the queue
// throughput: a step per cycle unless the queue is full, a beat per cycle unless i_stall
// the result sequencer sets the rate, 1 to 5 beats per step
// synchronous active-low reset empties pipeline and queue, registers take reset values
// the bottom cap step of sector zero gives no beat and is dropped before the queue
module cylinder_mesh_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  cmg_pkg::t_in               i_data,
    output logic                       o_stall,
    output logic                       o_valid,
    output cmg_pkg::t_out              o_data,
    input  logic                       i_stall,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cmg_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import cmg_pkg::*;

    logic [30:0]        r_radius;
    logic [30:0]        r_height;
    logic signed [31:0] r_cx;
    logic signed [31:0] r_cy;
    logic signed [31:0] r_cz;
    logic [N_W-1:0]     r_sectors;

    t_cfg      cfg;
    t_job      w_push_job;
    t_job      w_head_job;
    t_q_status w_qstat;
    logic      w_push;
    logic      w_pop;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= 31'h00010000;
            r_height  <= 31'h00010000;
            r_cx      <= '0;
            r_cy      <= '0;
            r_cz      <= '0;
            r_sectors <= N_W'(16);
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_RADIUS:   r_radius  <= pwdata[30:0];
                REG_HEIGHT:   r_height  <= pwdata[30:0];
                REG_CENTRE_X: r_cx      <= pwdata;
                REG_CENTRE_Y: r_cy      <= pwdata;
                REG_CENTRE_Z: r_cz      <= pwdata;
                REG_SECTORS:  r_sectors <= pwdata[N_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_RADIUS:   prdata = {1'b0, r_radius};
            REG_HEIGHT:   prdata = {1'b0, r_height};
            REG_CENTRE_X: prdata = r_cx;
            REG_CENTRE_Y: prdata = r_cy;
            REG_CENTRE_Z: prdata = r_cz;
            REG_SECTORS:  prdata = 32'(r_sectors);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        cfg.radius = r_radius;
        cfg.height = r_height;
        cfg.cx     = r_cx;
        cfg.cy     = r_cy;
        cfg.cz     = r_cz;
        if (r_sectors < N_W'(2)) begin
            cfg.nsec = N_W'(2);
        end else if (r_sectors > N_W'(MAX_SECTORS)) begin
            cfg.nsec = N_W'(MAX_SECTORS);
        end else begin
            cfg.nsec = r_sectors;
        end
    end

    cmg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .o_stall  (o_stall),
        .i_cfg    (cfg),
        .i_q_full (w_qstat.full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    cmg_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_qstat)
    );

    cmg_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_job    (w_head_job),
        .i_status (w_qstat),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .o_data   (o_data),
        .i_stall  (i_stall)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("job pushed into full queue");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.kind == KIND_ERROR) |-> o_data.last)
        else $error("error beat without last");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.count <= (Q_PTR_W+1)'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("pop from empty queue");

endmodule

// ===== test/tb_cylinder_mesh_generator.sv =====
// testbench of the cylinder mesh generator: directed table, random steps, predicted beats
module tb_cylinder_mesh_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import cmg_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;

    logic i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    t_in  i_data;
    t_out o_data;
    logic psel, penable, pwrite, pready;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    cylinder_mesh_generator dut (.*);

    // shadow registers of the block
    logic [30:0] sh_radius, sh_height;
    logic signed [31:0] sh_cx, sh_cy, sh_cz;
    logic [10:0] sh_nsec;

    t_out beats_due[$];
    int   errors = 0;
    int   send_idle = 14, recv_idle = 69;
    bit   hold_off = 0;
    int   quiet = 0;

    localparam logic [29:0] ARCTAN [30] = '{
        30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
        30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
        30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
        30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
        30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
        30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
    };

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint ring_coord(logic signed [31:0] ctr, longint trig);
        longint prod;
        prod = longint'({33'd0, sh_radius}) * trig + (64'sd1 <<< 29);
        return clamp32(longint'(ctr) + (prod >>> 30));
    endfunction

    function automatic void push_beat(logic [1:0] k, longint a, longint b, longint c);
        t_out r;
        r.kind = k;
        r.first_word = a[31:0];
        r.second_word = b[31:0];
        r.third_word = c[31:0];
        r.last = 0;
        beats_due.insert(beats_due.size(), r);
    endfunction

    // expected beats of one mesh step
    function automatic void predict_step(t_in s);
        longint n, j, cur, hub, x, y, z, dx, dy, tc, ts;
        logic [31:0] phase;
        logic signed [31:0] ytop, ybot;
        int start;
        start = beats_due.size();
        n = sh_nsec;
        if (n < 2) n = 2;
        if (n > MAX_SECTORS) n = MAX_SECTORS;
        j = s.sector;
        ytop = clamp32(longint'(sh_cy) + longint'(sh_height >> 1));
        ybot = clamp32(longint'(sh_cy) - longint'(sh_height >> 1));
        if (s.ring == RING_UNUSED || j >= n) begin
            push_beat(KIND_ERROR, 0, 0, 0);
        end else begin
            if (s.ring == RING_TOP && j == 0) push_beat(KIND_VERTEX, sh_cx, ytop, sh_cz);
            if (s.ring != RING_CAP) begin
                phase = 32'((j << 32) / n);
                x = 32'h26DD3B6A; y = 0; z = phase[29:0];
                for (int i = 0; i < 30; i++) begin
                    dx = y >>> i; dy = x >>> i;
                    if (z >= 0) begin
                        x -= dx; y += dy; z -= ARCTAN[i];
                    end else begin
                        x += dx; y -= dy; z += ARCTAN[i];
                    end
                end
                case (phase[31:30])
                    2'd0: begin tc = x; ts = y; end
                    2'd1: begin tc = -y; ts = x; end
                    2'd2: begin tc = -x; ts = -y; end
                    default: begin tc = y; ts = -x; end
                endcase
                push_beat(KIND_VERTEX, ring_coord(sh_cx, tc),
                          s.ring == RING_TOP ? ytop : ybot, ring_coord(sh_cz, ts));
            end
            if (j > 0) begin
                if (s.ring == RING_TOP) begin
                    push_beat(KIND_TRIANGLE, 0, j + 1, j);
                    if (j == n - 1) push_beat(KIND_TRIANGLE, 0, n, 1);
                end else if (s.ring == RING_BOTTOM) begin
                    cur = n + 1 + j;
                    push_beat(KIND_TRIANGLE, cur, cur - 1, cur - 1 - n);
                    push_beat(KIND_TRIANGLE, cur, cur - n, cur - n - 1);
                    if (j == n - 1) begin
                        push_beat(KIND_TRIANGLE, cur, cur - n, cur - 2 * n + 1);
                        push_beat(KIND_TRIANGLE, cur, cur - n + 1, cur - 2 * n + 1);
                    end
                end else begin
                    hub = 2 * n + 1;
                    if (j == 1) push_beat(KIND_VERTEX, sh_cx, ybot, sh_cz);
                    push_beat(KIND_TRIANGLE, hub, n + j + 1, n + j);
                    if (j == n - 1) push_beat(KIND_TRIANGLE, hub, n + j + 1, n + 1);
                end
            end
        end
        if (beats_due.size() > start) beats_due[beats_due.size() - 1].last = 1;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= ADDR_W'(idx) << 2; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            REG_RADIUS:   sh_radius = val[30:0];
            REG_HEIGHT:   sh_height = val[30:0];
            REG_CENTRE_X: sh_cx = val;
            REG_CENTRE_Y: sh_cy = val;
            REG_CENTRE_Z: sh_cz = val;
            default:      sh_nsec = val[10:0];
        endcase
    endtask

    // valid stays high from one accepted beat into the next unless the sender idles
    task automatic send_step(logic [1:0] r, logic [9:0] j);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_data <= '{ring: r, sector: j};
        do @(posedge i_clk); while (o_stall);
        predict_step('{ring: r, sector: j});
    endtask

    task automatic drain();
        i_valid <= 0;
        while (beats_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // random phase: mostly whole loops in order, some loose steps
    task automatic random_steps(int count);
        int k, n;
        k = 0;
        n = sh_nsec < 2 ? 2 : sh_nsec;
        while (k < count) begin
            if ($urandom_range(3) != 0 && n <= 24) begin
                for (int r = 0; r < 3; r++)
                    for (int j = 0; j < n; j++) begin
                        send_step(r[1:0], j[9:0]);
                        k++;
                    end
            end else begin
                send_step(2'($urandom_range(3)), $urandom_range(1) ? 10'($urandom_range(1023))
                          : 10'($urandom_range(n - 1)));
                k++;
            end
        end
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                quiet <= 0;
                if (beats_due.size() == 0) begin
                    $display("%0t: unexpected beat %h", $time, o_data);
                    errors++;
                end else begin
                    if (o_data.kind !== beats_due[0].kind ||
                        o_data.first_word !== beats_due[0].first_word ||
                        o_data.second_word !== beats_due[0].second_word ||
                        o_data.third_word !== beats_due[0].third_word ||
                        o_data.last !== beats_due[0].last) begin
                        $display("%0t: expected %h actual %h", $time, beats_due[0], o_data);
                        errors++;
                    end
                    void'(beats_due.pop_front());
                end
            end else if (i_valid && !o_stall) begin
                quiet <= 0;
            end else begin
                quiet <= quiet + 1;
            end
            i_stall <= hold_off || ($urandom_range(99) < recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    typedef struct {
        logic [1:0] ring;
        logic [9:0] sector;
        bit         typed;
        t_out       beat;
    } t_row;

    t_row rows[$];

    initial begin
        i_rst_n = 0; i_valid = 0; i_data = '0; i_stall = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        sh_radius = 31'h10000; sh_height = 31'h10000;
        sh_cx = 0; sh_cy = 0; sh_cz = 0; sh_nsec = 16;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset values: top centre vertex at (0, 0.5, 0), errors out of range
        rows.insert(rows.size(), '{RING_TOP, 0, 1, '{KIND_VERTEX, 0, 32'h8000, 0, 0}});
        rows.insert(rows.size(), '{RING_TOP, 0, 0, '0});
        for (int j = 1; j < 16; j++) rows.insert(rows.size(), '{RING_TOP, j[9:0], 0, '0});
        rows.insert(rows.size(), '{RING_BOTTOM, 0, 0, '0});
        rows.insert(rows.size(), '{RING_BOTTOM, 15, 0, '0});
        rows.insert(rows.size(), '{RING_CAP, 0, 0, '0});
        rows.insert(rows.size(), '{RING_CAP, 1, 0, '0});
        rows.insert(rows.size(), '{RING_CAP, 15, 0, '0});
        rows.insert(rows.size(), '{RING_TOP, 16, 1, '{KIND_ERROR, 0, 0, 0, 1}});
        rows.insert(rows.size(), '{RING_UNUSED, 0, 1, '{KIND_ERROR, 0, 0, 0, 1}});
        rows.insert(rows.size(), '{RING_CAP, 1023, 1, '{KIND_ERROR, 0, 0, 0, 1}});
        foreach (rows[i]) begin
            send_step(rows[i].ring, rows[i].sector);
            // the typed row replaces the predicted first beat
            if (rows[i].typed && rows[i].ring == RING_TOP && rows[i].sector == 0)
                beats_due[beats_due.size() - 2] = rows[i].beat;
            else if (rows[i].typed)
                beats_due[beats_due.size() - 1] = rows[i].beat;
        end
        drain();

        // long hold-off so the block fills and stalls its input
        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            for (int k = 0; k < 40; k++)
                send_step(2'($urandom_range(1)), 10'($urandom_range(15)));
        join
        drain();

        // extremes: huge radius, saturating centre, out-of-range counts
        write_reg(REG_RADIUS, 32'h7FFFFFFF);
        write_reg(REG_HEIGHT, 32'h7FFFFFFF);
        write_reg(REG_CENTRE_X, 32'h7FFFFFFF);
        write_reg(REG_CENTRE_Y, 32'h80000000);
        write_reg(REG_CENTRE_Z, 32'h80000000);
        write_reg(REG_SECTORS, 0);
        random_steps(60);
        drain();
        write_reg(REG_SECTORS, 11'h7FF);
        write_reg(REG_CENTRE_Y, 32'h7FFFFFFF);
        random_steps(60);
        drain();

        send_idle = 69; recv_idle = 14;
        write_reg(REG_RADIUS, 0);
        write_reg(REG_HEIGHT, 0);
        write_reg(REG_CENTRE_X, $urandom);
        write_reg(REG_CENTRE_Y, $urandom);
        write_reg(REG_CENTRE_Z, $urandom);
        write_reg(REG_SECTORS, 2);
        random_steps(80);
        drain();
        write_reg(REG_RADIUS, $urandom);
        write_reg(REG_HEIGHT, $urandom);
        write_reg(REG_SECTORS, 1024);
        random_steps(60);
        drain();

        send_idle = 0; recv_idle = 0;
        write_reg(REG_RADIUS, $urandom_range(32'h100000));
        write_reg(REG_CENTRE_X, $urandom);
        write_reg(REG_SECTORS, $urandom_range(3, 9));
        random_steps(120);
        drain();

        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
